// File: sv/nnsa_pkg.sv
// nnsa_pkg: widths, register codes, configuration and queue entry types
// for the nearest-neighbour scaler address unit; no dependencies
`default_nettype none

package nnsa_pkg;

  localparam int POS_W      = 28;
  localparam int OFS_W      = 27;
  localparam int DIM_W      = 13;
  localparam int BPP_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_READ_WIDTH   = 3'd0,
    REG_WRITE_WIDTH  = 3'd1,
    REG_WRITE_HEIGHT = 3'd2,
    REG_STEP_X       = 3'd3,
    REG_STEP_Y       = 3'd4,
    REG_READ_BPP     = 3'd5,
    REG_WRITE_BPP    = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [DIM_W-1:0] read_width;
    logic [DIM_W-1:0] write_width;
    logic [DIM_W-1:0] write_height;
    logic [POS_W-1:0] step_x;
    logic [POS_W-1:0] step_y;
    logic [BPP_W-1:0] read_bpp;
    logic [BPP_W-1:0] write_bpp;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    read_width:   DIM_W'(640),
    write_width:  DIM_W'(640),
    write_height: DIM_W'(480),
    step_x:       POS_W'(65536),
    step_y:       POS_W'(65536),
    read_bpp:     BPP_W'(1),
    write_bpp:    BPP_W'(1)
  };

  // one classified pixel between front and back
  typedef struct packed {
    logic [POS_W-1:0] x_pos;
    logic [POS_W-1:0] y_pos;
    logic [OFS_W-1:0] dst_ofs;
    logic             eol;
    logic             eof;
  } pix_t;

endpackage

`default_nettype wire

// File: sv/nnsa_if.sv
// nnsa_if: valid/ready channel interfaces for the restart input, the
// address result and the configuration writes; uses nnsa_pkg
`default_nettype none

interface nnsa_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface nnsa_out_if;
  import nnsa_pkg::*;
  logic             valid;
  logic             ready;
  logic [OFS_W-1:0] src_byte_offset;
  logic [OFS_W-1:0] dst_byte_offset;
  logic             end_of_line;
  logic             end_of_frame;

  modport source (output valid, output src_byte_offset, output dst_byte_offset,
                  output end_of_line, output end_of_frame, input ready);
  modport sink   (input valid, input src_byte_offset, input dst_byte_offset,
                  input end_of_line, input end_of_frame, output ready);
endinterface

interface nnsa_cfg_if;
  import nnsa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/nnsa_front.sv
// nnsa_front: raster walk over the output frame, fixed-point source
// positions and destination offset; uses nnsa_pkg and nnsa_if
`default_nettype none

module nnsa_front import nnsa_pkg::*; #(
  parameter int MAX_DIM   = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  nnsa_in_if.sink      in_i,
  output logic         push_o,
  output pix_t         push_data_o,
  input  logic         full_i
);

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int CMP_W = (CNT_W > DIM_W) ? CNT_W : DIM_W;

  function automatic logic [CMP_W-1:0] last_idx(input logic [DIM_W-1:0] v);
    logic [CMP_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (int'(v) > MAX_DIM) begin
      r = CMP_W'(MAX_DIM - 1);
    end else begin
      r = CMP_W'(v) - CMP_W'(1);
    end
    return r;
  endfunction

  logic [CNT_W-1:0] col_q, col_d, row_q, row_d, col_c, row_c;
  logic [POS_W-1:0] x_q, x_d, y_q, y_d, x_c, y_c;
  logic [OFS_W-1:0] dst_q, dst_d, dst_c, dst_inc;
  logic             eol, eof;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    col_c = in_i.restart ? '0 : col_q;
    row_c = in_i.restart ? '0 : row_q;
    x_c   = in_i.restart ? '0 : x_q;
    y_c   = in_i.restart ? '0 : y_q;
    dst_c = in_i.restart ? '0 : dst_q;

    eol     = CMP_W'(col_c) >= last_idx(cfg_i.write_width);
    eof     = eol && (CMP_W'(row_c) >= last_idx(cfg_i.write_height));
    dst_inc = dst_c + OFS_W'(cfg_i.write_bpp);

    if (eof) begin
      col_d = '0;
      row_d = '0;
      x_d   = '0;
      y_d   = '0;
      dst_d = '0;
    end else if (eol) begin
      col_d = '0;
      row_d = row_c + CNT_W'(1);
      x_d   = '0;
      y_d   = y_c + cfg_i.step_y;
      dst_d = dst_inc;
    end else begin
      col_d = col_c + CNT_W'(1);
      row_d = row_c;
      x_d   = x_c + cfg_i.step_x;
      y_d   = y_c;
      dst_d = dst_inc;
    end
  end

  assign push_data_o = '{x_pos: x_c, y_pos: y_c, dst_ofs: dst_c, eol: eol, eof: eof};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      x_q   <= '0;
      y_q   <= '0;
      dst_q <= '0;
    end else if (push_o) begin
      col_q <= col_d;
      row_q <= row_d;
      x_q   <= x_d;
      y_q   <= y_d;
      dst_q <= dst_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/nnsa_queue.sv
// nnsa_queue: two-entry queue of classified pixels between front and back;
// uses nnsa_pkg
`default_nettype none

module nnsa_queue import nnsa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  pix_t push_data_i,
  input  logic pop_i,
  output pix_t pop_data_o,
  output logic empty_o,
  output logic full_o
);

  pix_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign empty_o    = (count_q == 2'd0);
  assign full_o     = (count_q == 2'd2);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/nnsa_back.sv
// nnsa_back: source address arithmetic in two multiply stages, the second one
// feeding the output register; uses nnsa_pkg and nnsa_if
`default_nettype none

module nnsa_back import nnsa_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  pix_t       pop_data_i,
  input  logic       empty_i,
  output logic       pop_o,
  nnsa_out_if.source out_o
);

  localparam int INT_W = POS_W - FRAC_BITS;

  logic [INT_W-1:0] xi, yi;
  logic [OFS_W-1:0] lin_d, lin_q, src_d, src_q;
  logic [OFS_W-1:0] s1_dst_q, out_dst_q;
  logic             s1_eol_q, s1_eof_q, out_eol_q, out_eof_q;
  logic             s1_vld_q, out_vld_q;
  logic             out_en, s1_en;

  assign out_en = !out_vld_q || out_o.ready;
  assign s1_en  = !s1_vld_q || out_en;
  assign pop_o  = !empty_i && s1_en;

  assign xi    = pop_data_i.x_pos[POS_W-1:FRAC_BITS];
  assign yi    = pop_data_i.y_pos[POS_W-1:FRAC_BITS];
  assign lin_d = OFS_W'(yi) * OFS_W'(cfg_i.read_width) + OFS_W'(xi);
  assign src_d = lin_q * OFS_W'(cfg_i.read_bpp);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      lin_q    <= lin_d;
      s1_dst_q <= pop_data_i.dst_ofs;
      s1_eol_q <= pop_data_i.eol;
      s1_eof_q <= pop_data_i.eof;
    end
    if (out_en && s1_vld_q) begin
      src_q     <= src_d;
      out_dst_q <= s1_dst_q;
      out_eol_q <= s1_eol_q;
      out_eof_q <= s1_eof_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_vld_q <= pop_o;
      end
      if (out_en) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.src_byte_offset = src_q;
  assign out_o.dst_byte_offset = out_dst_q;
  assign out_o.end_of_line     = out_eol_q;
  assign out_o.end_of_frame    = out_eof_q;

endmodule

`default_nettype wire

// File: sv/nearest_neighbour_scaler_address_unit.sv
// nearest_neighbour_scaler_address_unit: top level, configuration registers,
// front, queue and back; uses nnsa_pkg, nnsa_if, nnsa_front, nnsa_queue, nnsa_back
//
//   port    dir   beat carries
//   in_i    sink  restart
//   out_o   src   src_byte_offset, dst_byte_offset, end_of_line, end_of_frame
//   cfg_i   sink  index, data (always ready)
//
// one pixel a cycle sustained while out_o is ready, the front updating its counters on each accepted beat
// result is registered in the queue, the product stage and the output register in turn
// two-entry queue lets the front keep accepting while the back is stalled, until it is full
// reset returns registers to defaults and the walk to the origin, no clearing pass
`default_nettype none

module nearest_neighbour_scaler_address_unit import nnsa_pkg::*; #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  nnsa_in_if.sink    in_i,
  nnsa_out_if.source out_o,
  nnsa_cfg_if.sink   cfg_i
);

  cfg_t cfg_q;
  pix_t push_data, pop_data;
  logic push, pop, full, empty;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_READ_WIDTH:   cfg_q.read_width   <= cfg_i.data[DIM_W-1:0];
        REG_WRITE_WIDTH:  cfg_q.write_width  <= cfg_i.data[DIM_W-1:0];
        REG_WRITE_HEIGHT: cfg_q.write_height <= cfg_i.data[DIM_W-1:0];
        REG_STEP_X:       cfg_q.step_x       <= cfg_i.data[POS_W-1:0];
        REG_STEP_Y:       cfg_q.step_y       <= cfg_i.data[POS_W-1:0];
        REG_READ_BPP:     cfg_q.read_bpp     <= cfg_i.data[BPP_W-1:0];
        REG_WRITE_BPP:    cfg_q.write_bpp    <= cfg_i.data[BPP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  nnsa_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_i        (in_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  nnsa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty),
    .full_o      (full)
  );

  nnsa_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .pop_data_i (pop_data),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

// File: sv/nnsa_checker.sv
// nnsa_checker: port-level assertions for the scaler address unit and the
// bind that attaches them; uses nnsa_pkg
`default_nettype none

module nnsa_checker import nnsa_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [OFS_W-1:0] src_i,
  input logic [OFS_W-1:0] dst_i,
  input logic             eol_i,
  input logic             eof_i
);

  logic [2:0] pend_q;
  logic       eof_seen_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      eof_seen_q <= 1'b0;
    end else begin
      pend_q <= pend_q + 3'(in_acc) - 3'(out_acc);
      if (out_acc) begin
        eof_seen_q <= eof_i;
      end
    end
  end

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable({src_i, dst_i, eol_i, eof_i}))
    else $error("result payload changed while stalled");

  a_eof_is_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && eof_i |-> eol_i)
    else $error("end of frame without end of line");

  a_frame_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && eof_seen_q |-> dst_i == '0)
    else $error("first pixel after end of frame not at destination origin");

  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q != '0)
    else $error("result delivered with no pixel outstanding");

endmodule

bind nearest_neighbour_scaler_address_unit nnsa_checker u_nnsa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .src_i       (out_o.src_byte_offset),
  .dst_i       (out_o.dst_byte_offset),
  .eol_i       (out_o.end_of_line),
  .eof_i       (out_o.end_of_frame)
);

`default_nettype wire
